FILE: rtl/dsw_pkg.sv
package dsw_pkg;

   localparam int DIGIT_COUNT = 8;
   localparam int DIGIT_W = 4;
   localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int STEP_W = 3;
   localparam int VALUE_W = 32;
   localparam int MASK_W = 8;
   localparam int BRIGHT_W = 3;

   localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
   localparam logic [7:0] CMD_WRITE_FIXED = 8'h44;
   localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
   localparam logic [7:0] LED_ON_BYTE = 8'hFF;
   localparam logic [7:0] LED_OFF_BYTE = 8'h00;
   localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int DEC_SHIFT = 35;

   localparam logic [STEP_W-1:0] STEP_ON = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MODE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SEG_ADDR = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SEG = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LED_ADDR = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LED = 3'd5;

   typedef struct packed {
      logic [VALUE_W-1:0] number_value;
      logic               hex_mode;
      logic [MASK_W-1:0]  led_mask;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       frame_start;
      logic       frame_end;
      logic       last_byte;
   } rsp_payload_type;

   // data handed from one digit cell to the next
   typedef struct packed {
      logic                           valid;
      logic [VALUE_W-1:0]             value;
      logic                           hex_mode;
      logic [DIGIT_COUNT-1:0]         led_mask;
      logic [DIGIT_COUNT*DIGIT_W-1:0] digits;
   } cell_data_type;

   function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [7:0] pat;
      begin
         unique case (digit)
            4'h0: pat = 8'h3F;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5B;
            4'h3: pat = 8'h4F;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6D;
            4'h6: pat = 8'h7D;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7F;
            4'h9: pat = 8'h6F;
            4'hA: pat = 8'h77;
            4'hB: pat = 8'h7C;
            4'hC: pat = 8'h39;
            4'hD: pat = 8'h5E;
            4'hE: pat = 8'h79;
            default: pat = 8'h71;
         endcase
         return pat;
      end
   endfunction

endpackage

FILE: rtl/seven_segment_number_display_writer_top.sv
// Seven-segment number display writer. Each accepted item (value, hex/decimal mode, LED
// mask) is turned into 48 command bytes, six per digit position, leftmost first, each
// tagged with strobe frame bounds and last_byte on the final one. Digits are produced by
// a chain of eight cells, one digit per cell per cycle, before the item lands in a
// one-item buffer; the byte emitter then sends one byte per cycle while rsp_ready allows,
// through a registered output. The next item is accepted while the current one is still
// being sent. Brightness may be written at any time the block is idle.
module seven_segment_number_display_writer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dsw_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dsw_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dsw_pkg::BRIGHT_W-1:0]      csr_data
);
   import dsw_pkg::*;

   logic [BRIGHT_W-1:0] brightness_ff, brightness_in;
   cell_data_type       chain_w [DIGIT_COUNT+1];
   logic [DIGIT_COUNT:1] chain_valid_w;
   logic                chain_busy;
   logic                buf_busy;

   assign csr_ready = 1'b1;
   assign brightness_in = (csr_valid && csr_ready) ? csr_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_W'(2);
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   // take a new item only when the chain and the buffer behind it are empty
   assign req_ready = !chain_busy && !buf_busy;

   assign chain_w[0] = {req_valid && req_ready, req_data.number_value, req_data.hex_mode,
                        req_data.led_mask[DIGIT_COUNT-1:0], {(DIGIT_COUNT*DIGIT_W){1'b0}}};

   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
      dsw_digit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain_w[i]),
         .cell_out (chain_w[i+1])
      );
   end

   always_comb begin
      for (int j = 1; j <= DIGIT_COUNT; j++) begin
         chain_valid_w[j] = chain_w[j].valid;
      end
   end

   assign chain_busy = |chain_valid_w;

   dsw_byte_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .conv_in    (chain_w[DIGIT_COUNT]),
      .brightness (brightness_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .buf_busy   (buf_busy)
   );

endmodule

FILE: rtl/dsw_digit_cell.sv
module dsw_digit_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dsw_pkg::cell_data_type cell_in,
   output dsw_pkg::cell_data_type cell_out
);
   import dsw_pkg::*;

   logic [2*VALUE_W-1:0] product_w;
   logic [VALUE_W-1:0]   quot_w;
   logic [VALUE_W-1:0]   rem_w;
   logic [DIGIT_W-1:0]   digit_w;
   logic [VALUE_W-1:0]   next_value_w;

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;

   // divide by ten through the reciprocal, then remainder by shift-add
   assign product_w = (2*VALUE_W)'(cell_in.value) * (2*VALUE_W)'(DEC_RECIP);
   assign quot_w = VALUE_W'(product_w >> DEC_SHIFT);
   assign rem_w = cell_in.value - (quot_w << 3) - (quot_w << 1);

   always_comb begin
      if (cell_in.hex_mode) begin
         digit_w = cell_in.value[DIGIT_W-1:0];
         next_value_w = cell_in.value >> DIGIT_W;
      end else begin
         digit_w = rem_w[DIGIT_W-1:0];
         next_value_w = quot_w;
      end
   end

   always_comb begin
      valid_in = cell_in.valid;
      data_in = cell_in;
      data_in.value = next_value_w;
      // shift the new digit in from the top: the rightmost digit ends lowest
      data_in.digits = {digit_w, cell_in.digits[DIGIT_COUNT*DIGIT_W-1:DIGIT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

FILE: rtl/dsw_byte_emitter.sv
module dsw_byte_emitter (
   input  logic                               clock,
   input  logic                               reset,
   input  dsw_pkg::cell_data_type             conv_in,
   input  logic [dsw_pkg::BRIGHT_W-1:0]       brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dsw_pkg::rsp_payload_type           rsp_data,
   output logic                               buf_busy
);
   import dsw_pkg::*;

   logic          buf_valid_ff, buf_valid_in;
   cell_data_type buf_ff, buf_in;
   logic          act_valid_ff, act_valid_in;
   cell_data_type act_ff, act_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              out_free, advance, last_w, finish, act_take;
   logic [POS_W-1:0]  slot_w;
   logic [DIGIT_W-1:0] digit_w;
   logic [7:0]        addr_w;
   rsp_payload_type   byte_w;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = act_valid_ff && out_free;
   assign last_w = (pos_ff == POS_W'(DIGIT_COUNT - 1)) && (step_ff == STEP_LED);
   assign finish = advance && last_w;
   assign act_take = buf_valid_ff && (!act_valid_ff || finish);

   // leftmost position sits in the highest digit slot
   assign slot_w = POS_W'(DIGIT_COUNT - 1) - pos_ff;
   assign digit_w = act_ff.digits[{slot_w, 2'b00} +: DIGIT_W];
   assign addr_w = CMD_ADDR_BASE + (8'(pos_ff) << 1);

   always_comb begin
      byte_w = '0;
      unique case (step_ff)
         STEP_ON: begin
            byte_w.cmd_byte = CMD_DISPLAY_ON | 8'(brightness);
            byte_w.frame_start = 1'b1;
            byte_w.frame_end = 1'b1;
         end
         STEP_MODE: begin
            byte_w.cmd_byte = CMD_WRITE_FIXED;
            byte_w.frame_start = 1'b1;
            byte_w.frame_end = 1'b1;
         end
         STEP_SEG_ADDR: begin
            byte_w.cmd_byte = addr_w;
            byte_w.frame_start = 1'b1;
         end
         STEP_SEG: begin
            byte_w.cmd_byte = seg_pattern(digit_w);
            byte_w.frame_end = 1'b1;
         end
         STEP_LED_ADDR: begin
            byte_w.cmd_byte = addr_w + 8'd1;
            byte_w.frame_start = 1'b1;
         end
         default: begin
            byte_w.cmd_byte = act_ff.led_mask[slot_w] ? LED_ON_BYTE : LED_OFF_BYTE;
            byte_w.frame_end = 1'b1;
         end
      endcase
      byte_w.last_byte = last_w;
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_in = buf_ff;
      if (conv_in.valid) begin
         buf_valid_in = 1'b1;
         buf_in = conv_in;
      end else if (act_take) begin
         buf_valid_in = 1'b0;
      end

      act_valid_in = act_valid_ff;
      act_in = act_ff;
      pos_in = pos_ff;
      step_in = step_ff;
      if (act_take) begin
         act_valid_in = 1'b1;
         act_in = buf_ff;
         pos_in = '0;
         step_in = STEP_ON;
      end else if (finish) begin
         act_valid_in = 1'b0;
      end else if (advance) begin
         if (step_ff == STEP_LED) begin
            step_in = STEP_ON;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in = byte_w;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         act_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff <= '0;
         step_ff <= STEP_ON;
      end else begin
         buf_valid_ff <= buf_valid_in;
         act_valid_ff <= act_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      act_ff <= act_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign buf_busy = buf_valid_ff;

endmodule

FILE: bench/testbench.sv
import dsw_pkg::*;

class cmd_stream_scoreboard;
   rsp_payload_type      pending_bytes[$];
   logic [BRIGHT_W-1:0]  brightness;
   logic [127:0]         glyphs;
   int                   mismatch_count;
   int                   byte_count;

   function new();
      brightness = 3'd2;
      // segment patterns for digits 0..F, digit 0 in the low byte
      glyphs = 128'h7179_5E39_7C77_6F7F_077D_6D66_4F5B_063F;
      mismatch_count = 0;
      byte_count = 0;
   endfunction

   function void set_brightness(logic [BRIGHT_W-1:0] level);
      brightness = level;
   endfunction

   function void push_byte(logic [7:0] cmd, logic fs, logic fe, logic last);
      rsp_payload_type b;
      b.cmd_byte = cmd;
      b.frame_start = fs;
      b.frame_end = fe;
      b.last_byte = last;
      pending_bytes.push_back(b);
   endfunction

   // expand one accepted item into its 48 command bytes
   function void expand_number(req_payload_type item);
      logic [DIGIT_W-1:0] digit [DIGIT_COUNT];
      logic [VALUE_W-1:0] rest;
      logic [7:0]         addr;
      logic [7:0]         led;
      rest = item.number_value;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (item.hex_mode) begin
            digit[DIGIT_COUNT-1-i] = rest[DIGIT_W-1:0];
            rest = rest >> DIGIT_W;
         end else begin
            digit[DIGIT_COUNT-1-i] = DIGIT_W'(rest % 32'd10);
            rest = rest / 32'd10;
         end
      end
      for (int pos = 0; pos < DIGIT_COUNT; pos++) begin
         addr = CMD_ADDR_BASE + 8'(2 * pos);
         led = item.led_mask[DIGIT_COUNT-1-pos] ? LED_ON_BYTE : LED_OFF_BYTE;
         push_byte(CMD_DISPLAY_ON | 8'(brightness), 1'b1, 1'b1, 1'b0);
         push_byte(CMD_WRITE_FIXED, 1'b1, 1'b1, 1'b0);
         push_byte(addr, 1'b1, 1'b0, 1'b0);
         push_byte(glyphs[digit[pos]*8 +: 8], 1'b0, 1'b1, 1'b0);
         push_byte(addr + 8'd1, 1'b1, 1'b0, 1'b0);
         push_byte(led, 1'b0, 1'b1, pos == DIGIT_COUNT - 1);
      end
   endfunction

   task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task check_byte(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_bytes.size() == 0) begin
         flag_mismatch($sformatf("byte %0d: unexpected cmd_byte %02h", byte_count,
                                 got.cmd_byte));
      end else begin
         want = pending_bytes.pop_front();
         if (got.cmd_byte !== want.cmd_byte)
            flag_mismatch($sformatf("byte %0d: cmd_byte %02h, want %02h", byte_count,
                                    got.cmd_byte, want.cmd_byte));
         if (got.frame_start !== want.frame_start)
            flag_mismatch($sformatf("byte %0d: frame_start %b, want %b", byte_count,
                                    got.frame_start, want.frame_start));
         if (got.frame_end !== want.frame_end)
            flag_mismatch($sformatf("byte %0d: frame_end %b, want %b", byte_count,
                                    got.frame_end, want.frame_end));
         if (got.last_byte !== want.last_byte)
            flag_mismatch($sformatf("byte %0d: last_byte %b, want %b", byte_count,
                                    got.last_byte, want.last_byte));
      end
      byte_count++;
   endtask
endclass

module testbench;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 64;
   localparam int LONG_HOLD = 400;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [BRIGHT_W-1:0]   csr_data = '0;

   cmd_stream_scoreboard  sb;
   bit                    idle_on = 1'b1;
   bit                    hold_request = 1'b0;
   int                    cycle_count = 0;

   seven_segment_number_display_writer_top u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_data
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_byte(rsp_data);
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int burst;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input req_payload_type item);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.expand_number(item);
   endtask

   task automatic send_fields(input logic [VALUE_W-1:0] value, input logic hex,
                              input logic [MASK_W-1:0] mask);
      req_payload_type item;
      item.number_value = value;
      item.hex_mode = hex;
      item.led_mask = mask;
      send_item(item);
   endtask

   function automatic req_payload_type random_item();
      req_payload_type item;
      case ($urandom_range(0, 4))
         0: item.number_value = $urandom_range(0, 99999999);
         // straddle the eight-digit decimal wrap
         1: item.number_value = 32'd99999990 + 32'($urandom_range(0, 20));
         2: item.number_value = 32'($urandom_range(0, 255));
         default: item.number_value = $urandom;
      endcase
      item.hex_mode = 1'($urandom_range(0, 1));
      item.led_mask = 8'($urandom);
      return item;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_item(random_item());
   endtask

   // drop valid and wait for every pending byte
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_brightness(input logic [BRIGHT_W-1:0] level);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= level;
      do @(posedge clock); while (!csr_ready);
      sb.set_brightness(level);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : main
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items at the reset brightness
      send_fields(32'd0, 1'b0, 8'h00);
      send_fields(32'd0, 1'b1, 8'hFF);
      send_fields(32'hFFFF_FFFF, 1'b0, 8'hFF);
      send_fields(32'hFFFF_FFFF, 1'b1, 8'h00);
      send_fields(32'd99999999, 1'b0, 8'h01);
      send_fields(32'd100000000, 1'b0, 8'h80);
      send_fields(32'd4000000000, 1'b0, 8'h3C);
      send_fields(32'h0123_4567, 1'b1, 8'hAA);
      send_fields(32'h89AB_CDEF, 1'b1, 8'h55);
      send_fields(32'hFEDC_BA98, 1'b1, 8'h5A);
      send_fields(32'd12345678, 1'b0, 8'h0F);
      send_fields(32'd87654321, 1'b0, 8'hF0);
      send_fields(32'd1, 1'b0, 8'h01);
      send_fields(32'h10, 1'b1, 8'h02);
      send_fields(32'd1234567890, 1'b0, 8'hC3);
      send_fields(32'h8000_0000, 1'b1, 8'h7E);
      drain();

      write_brightness(3'd7);
      send_random(60);
      drain();

      // long result stall while items keep coming
      write_brightness(3'd0);
      hold_request = 1'b1;
      send_random(60);
      drain();

      write_brightness(3'($urandom_range(1, 6)));
      send_random(60);
      drain();

      idle_on = 1'b0;
      write_brightness(3'd5);
      send_random(70);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_bytes.size() != 0)
         sb.flag_mismatch($sformatf("%0d bytes never arrived", sb.pending_bytes.size()));
      if (sb.mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/dsw_pkg.sv
rtl/dsw_digit_cell.sv
rtl/dsw_byte_emitter.sv
rtl/seven_segment_number_display_writer_top.sv
bench/testbench.sv
